// ----- rtl/i2cw_pkg.sv -----
// Shared types and constants for the I2C codec register writer.
package i2cw_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACK_TIMEOUT    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SETUP_TICKS    = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIT_TICKS      = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h34;
   localparam logic [7:0] ACK_TIMEOUT_RESET    = 8'd10;
   localparam logic [7:0] SETUP_TICKS_RESET    = 8'd3;
   localparam logic [7:0] BIT_TICKS_RESET      = 8'd1;

   // Operation codes carried by the request.
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Protocol phases.
   localparam int PHASE_WIDTH = 4;
   localparam logic [PHASE_WIDTH-1:0] PH_IDLE        = 4'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_START_SDA   = 4'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_START_SCL   = 4'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_BYTE_BEGIN  = 4'd3;
   localparam logic [PHASE_WIDTH-1:0] PH_BIT_SET     = 4'd4;
   localparam logic [PHASE_WIDTH-1:0] PH_BIT_HIGH    = 4'd5;
   localparam logic [PHASE_WIDTH-1:0] PH_BIT_LOW     = 4'd6;
   localparam logic [PHASE_WIDTH-1:0] PH_ACK_RELEASE = 4'd7;
   localparam logic [PHASE_WIDTH-1:0] PH_ACK_HIGH    = 4'd8;
   localparam logic [PHASE_WIDTH-1:0] PH_ACK_POLL    = 4'd9;
   localparam logic [PHASE_WIDTH-1:0] PH_STOP_BEGIN  = 4'd10;
   localparam logic [PHASE_WIDTH-1:0] PH_STOP_SDA    = 4'd11;
   localparam logic [PHASE_WIDTH-1:0] PH_STOP_SCL    = 4'd12;
   localparam logic [PHASE_WIDTH-1:0] PH_ABORT_END   = 4'd13;

   typedef struct packed {
      logic [7:0] device_address;
      logic [7:0] ack_timeout;
      logic [7:0] setup_ticks;
      logic [7:0] bit_ticks;
   } cfg_type;

   typedef struct packed {
      logic scl;
      logic sda_out;
      logic sda_drive;
      logic busy_res;
      logic done_res;
      logic ack_error;
   } result_type;

endpackage

// ----- rtl/i2cw_csr.sv -----
// Configuration register file of the I2C codec register writer.
module i2cw_csr
   import i2cw_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS: cfg_in.device_address = csr_write_data;
            CSR_ACK_TIMEOUT:    cfg_in.ack_timeout    = csr_write_data;
            CSR_SETUP_TICKS:    cfg_in.setup_ticks    = csr_write_data;
            CSR_BIT_TICKS:      cfg_in.bit_ticks      = csr_write_data;
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address <= DEVICE_ADDRESS_RESET;
         cfg_ff.ack_timeout    <= ACK_TIMEOUT_RESET;
         cfg_ff.setup_ticks    <= SETUP_TICKS_RESET;
         cfg_ff.bit_ticks      <= BIT_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/i2cw_core.sv -----
// Protocol state machine that advances the I2C lines by one tick per step.
module i2cw_core
   import i2cw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       op,
   input  logic [6:0] reg_addr,
   input  logic [8:0] reg_data,
   input  logic       sda_in,
   input  cfg_type    cfg,
   output result_type result
);

   logic [PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic [7:0]             wait_ff, wait_in;
   logic [2:0]             bit_ff, bit_in;
   logic [1:0]             byte_ff, byte_in;
   logic [15:0]            frame_ff, frame_in;
   logic [7:0]             ack_ff, ack_in;
   logic                   scl_ff, scl_in;
   logic                   sda_ff, sda_in_next;
   logic                   drive_ff, drive_in;

   logic [7:0] cur_byte;
   logic [7:0] ack_next;
   logic       done;
   logic       err;
   logic       ack_ok;
   logic       ack_fail;

   always_comb begin
      case (byte_ff)
         2'd0:    cur_byte = cfg.device_address;
         2'd1:    cur_byte = frame_ff[15:8];
         default: cur_byte = frame_ff[7:0];
      endcase
   end

   assign ack_next = ack_ff + 8'd1;

   always_comb begin
      phase_in    = phase_ff;
      wait_in     = wait_ff;
      bit_in      = bit_ff;
      byte_in     = byte_ff;
      frame_in    = frame_ff;
      ack_in      = ack_ff;
      scl_in      = scl_ff;
      sda_in_next = sda_ff;
      drive_in    = drive_ff;
      done        = 1'b0;
      err         = 1'b0;
      ack_ok      = 1'b0;
      ack_fail    = 1'b0;

      if (phase_ff == PH_IDLE) begin
         if (op == OP_WRITE) begin
            frame_in    = {reg_addr, reg_data};
            byte_in     = 2'd0;
            bit_in      = 3'd0;
            ack_in      = 8'd0;
            scl_in      = 1'b1;
            sda_in_next = 1'b1;
            drive_in    = 1'b1;
            wait_in     = cfg.setup_ticks;
            phase_in    = PH_START_SDA;
         end
      end else if (wait_ff > 8'd1) begin
         wait_in = wait_ff - 8'd1;
      end else begin
         wait_in = 8'd0;
         unique case (phase_ff)
            PH_START_SDA: begin
               sda_in_next = 1'b0;
               wait_in     = cfg.setup_ticks;
               phase_in    = PH_START_SCL;
            end
            PH_START_SCL: begin
               scl_in   = 1'b0;
               wait_in  = cfg.setup_ticks;
               phase_in = PH_BYTE_BEGIN;
            end
            PH_BYTE_BEGIN: begin
               drive_in = 1'b1;
               bit_in   = 3'd7;
               wait_in  = cfg.setup_ticks;
               phase_in = PH_BIT_SET;
            end
            PH_BIT_SET: begin
               sda_in_next = cur_byte[bit_ff];
               wait_in     = cfg.bit_ticks;
               phase_in    = PH_BIT_HIGH;
            end
            PH_BIT_HIGH: begin
               scl_in   = 1'b1;
               wait_in  = cfg.bit_ticks;
               phase_in = PH_BIT_LOW;
            end
            PH_BIT_LOW: begin
               scl_in  = 1'b0;
               wait_in = cfg.bit_ticks;
               if (bit_ff == 3'd0) begin
                  phase_in = PH_ACK_RELEASE;
               end else begin
                  bit_in   = bit_ff - 3'd1;
                  phase_in = PH_BIT_SET;
               end
            end
            PH_ACK_RELEASE: begin
               drive_in = 1'b0;
               wait_in  = cfg.setup_ticks;
               phase_in = PH_ACK_HIGH;
            end
            PH_ACK_HIGH: begin
               scl_in   = 1'b1;
               ack_in   = 8'd0;
               wait_in  = 8'd1;
               phase_in = PH_ACK_POLL;
            end
            PH_ACK_POLL: begin
               if (ack_ff >= cfg.ack_timeout) begin
                  ack_fail = 1'b1;
               end else begin
                  ack_in = ack_next;
                  if (!sda_in) begin
                     ack_ok = 1'b1;
                  end else if (ack_next >= cfg.ack_timeout) begin
                     ack_fail = 1'b1;
                  end else begin
                     wait_in = 8'd1;
                  end
               end
               if (ack_ok) begin
                  scl_in  = 1'b0;
                  wait_in = cfg.setup_ticks;
                  if (byte_ff < 2'd2) begin
                     byte_in  = byte_ff + 2'd1;
                     phase_in = PH_BYTE_BEGIN;
                  end else begin
                     phase_in = PH_STOP_BEGIN;
                  end
               end else if (ack_fail) begin
                  scl_in   = 1'b0;
                  wait_in  = cfg.setup_ticks;
                  phase_in = PH_ABORT_END;
               end
            end
            PH_STOP_BEGIN: begin
               scl_in      = 1'b0;
               sda_in_next = 1'b0;
               drive_in    = 1'b1;
               wait_in     = cfg.setup_ticks;
               phase_in    = PH_STOP_SDA;
            end
            PH_STOP_SDA: begin
               sda_in_next = 1'b1;
               wait_in     = cfg.setup_ticks;
               phase_in    = PH_STOP_SCL;
            end
            PH_STOP_SCL: begin
               scl_in   = 1'b1;
               done     = 1'b1;
               phase_in = PH_IDLE;
            end
            PH_ABORT_END: begin
               done     = 1'b1;
               err      = 1'b1;
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         wait_ff  <= 8'd0;
         bit_ff   <= 3'd0;
         byte_ff  <= 2'd0;
         frame_ff <= 16'd0;
         ack_ff   <= 8'd0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         drive_ff <= 1'b1;
      end else if (step) begin
         phase_ff <= phase_in;
         wait_ff  <= wait_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         frame_ff <= frame_in;
         ack_ff   <= ack_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in_next;
         drive_ff <= drive_in;
      end
   end

   assign result.scl       = scl_in;
   assign result.sda_out   = sda_in_next;
   assign result.sda_drive = drive_in;
   assign result.busy_res  = (phase_in != PH_IDLE);
   assign result.done_res  = done;
   assign result.ack_error = err;

endmodule

// ----- rtl/i2c_codec_register_writer_top.sv -----
// Top level of the I2C codec register writer: request and result registers around the core.
//
// This block is a bit-level I2C master that writes one 9-bit value into a
// codec register. Every request transfer is one tick of the bus timing: op 0
// is a plain tick and op 1 starts a register write, which is ignored while a
// write is already in progress. The write sends a start condition, the
// device address byte, then {reg_addr, reg_data[8]} and reg_data[7:0], each
// byte followed by an acknowledge poll on sda_in, and finally a stop
// condition. A poll that times out ends the write without a stop and reports
// done_res with ack_error set. Every request transfer produces exactly one
// result transfer that carries the line levels after that tick. The block
// takes one request per clock cycle while the result side does not stall: the
// request register feeds the protocol state machine, whose next line levels
// load the result register once it is free or being emptied. A new request is
// taken while a finished result still waits, as long as the request register
// can move on. The configuration registers must be written only while no write
// is in progress; the block itself does not enforce this.
module i2c_codec_register_writer_top
   import i2cw_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_op,
   input  logic [6:0]                 req_reg_addr,
   input  logic [8:0]                 req_reg_data,
   input  logic                       req_sda_in,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_scl,
   output logic                       rsp_sda_out,
   output logic                       rsp_sda_drive,
   output logic                       rsp_busy_res,
   output logic                       rsp_done_res,
   output logic                       rsp_ack_error,

   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   cfg_type    cfg;
   result_type core_result;

   // Request register. It holds one accepted tick until the core takes it.
   logic       req_valid_ff, req_valid_in;
   logic       op_ff;
   logic [6:0] reg_addr_ff;
   logic [8:0] reg_data_ff;
   logic       sda_in_ff;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   logic req_transfer;
   logic advance;

   // The core steps whenever a tick is waiting and the result register is
   // free or is being emptied in this same cycle.
   assign advance      = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = req_valid_ff && !advance;
   assign req_transfer = req_valid && !req_stall;

   always_comb begin
      if (req_transfer) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset; they load only with their valid bit.
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         op_ff       <= req_op;
         reg_addr_ff <= req_reg_addr;
         reg_data_ff <= req_reg_data;
         sda_in_ff   <= req_sda_in;
      end
      if (advance) begin
         rsp_ff <= core_result;
      end
   end

   i2cw_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   i2cw_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .op       (op_ff),
      .reg_addr (reg_addr_ff),
      .reg_data (reg_data_ff),
      .sda_in   (sda_in_ff),
      .cfg      (cfg),
      .result   (core_result)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl       = rsp_ff.scl;
   assign rsp_sda_out   = rsp_ff.sda_out;
   assign rsp_sda_drive = rsp_ff.sda_drive;
   assign rsp_busy_res  = rsp_ff.busy_res;
   assign rsp_done_res  = rsp_ff.done_res;
   assign rsp_ack_error = rsp_ff.ack_error;

   // A finished write leaves the block idle.
   a_done_not_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> !rsp_ff.busy_res)
      else $error("done reported while still busy");

   // An error is only ever reported together with done.
   a_error_with_done : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.ack_error |-> rsp_ff.done_res)
      else $error("ack_error without done");

   // A successful write ends on a stop condition: both lines high, SDA driven.
   a_stop_levels : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res && !rsp_ff.ack_error
      |-> rsp_ff.scl && rsp_ff.sda_out && rsp_ff.sda_drive)
      else $error("successful write did not end on a stop condition");

   // An aborted write ends with SDA still released from the failed poll.
   a_abort_released : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.ack_error |-> !rsp_ff.sda_drive && !rsp_ff.scl)
      else $error("aborted write did not leave SDA released and SCL low");

   // Every core step puts a result into the result register.
   a_step_fills_result : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("core step did not produce a result");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the I2C codec register writer: stimulus, line-level predictor, checks.
module tb_top
   import i2cw_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // The run is about 1200 request transfers, nearly all of them single bus
   // ticks. The limit below is far above the worst case, in which every one of
   // them waits out the longest sender gap and the longest receiver stall.
   localparam int CYCLE_LIMIT = 4_000_000;

   // A poll plan above any possible ack_timeout never pulls SDA low.
   localparam int NEVER_ACK = 300;

   // Expected line levels are predicted per request transfer and checked in order
   // against the result transfers.
   class i2c_line_scoreboard;
      cfg_type                cfg;
      logic [PHASE_WIDTH-1:0] phase;
      logic [7:0]             wait_count;
      logic [7:0]             ack_count;
      logic [2:0]             bit_index;
      logic [1:0]             byte_index;
      logic [15:0]            frame_bytes;
      logic                   scl, sda, drive;
      result_type             expected_levels[$];
      int                     errors;

      function new();
         cfg.device_address = DEVICE_ADDRESS_RESET;
         cfg.ack_timeout    = ACK_TIMEOUT_RESET;
         cfg.setup_ticks    = SETUP_TICKS_RESET;
         cfg.bit_ticks      = BIT_TICKS_RESET;
         phase       = PH_IDLE;
         wait_count  = '0;
         ack_count   = '0;
         bit_index   = '0;
         byte_index  = '0;
         frame_bytes = '0;
         scl         = 1'b1;
         sda         = 1'b1;
         drive       = 1'b1;
         errors      = 0;
      endfunction

      function void set_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
         case (index)
            CSR_DEVICE_ADDRESS: cfg.device_address = value;
            CSR_ACK_TIMEOUT:    cfg.ack_timeout    = value;
            CSR_SETUP_TICKS:    cfg.setup_ticks    = value;
            CSR_BIT_TICKS:      cfg.bit_ticks      = value;
            default: ;
         endcase
      endfunction

      // Advance the bus state by one tick and queue the levels it leaves behind.
      function void take_request(input logic op, input logic [6:0] reg_addr,
                                 input logic [8:0] reg_data, input logic sda_in);
         logic       done, err, poll_ok, poll_fail;
         logic [7:0] tx_byte;
         result_type levels;
         done = 1'b0;
         err  = 1'b0;
         if (byte_index == 2'd0) begin
            tx_byte = cfg.device_address;
         end else if (byte_index == 2'd1) begin
            tx_byte = frame_bytes[15:8];
         end else begin
            tx_byte = frame_bytes[7:0];
         end

         if (phase == PH_IDLE) begin
            if (op == OP_WRITE) begin
               frame_bytes = {reg_addr, reg_data};
               byte_index  = '0;
               bit_index   = '0;
               ack_count   = '0;
               scl         = 1'b1;
               sda         = 1'b1;
               drive       = 1'b1;
               wait_count  = cfg.setup_ticks;
               phase       = PH_START_SDA;
            end
         end else if (wait_count > 8'd1) begin
            wait_count = wait_count - 8'd1;
         end else begin
            // A wait of zero ends on the same tick as a wait of one.
            wait_count = '0;
            case (phase)
               PH_START_SDA: begin
                  sda = 1'b0;
                  wait_count = cfg.setup_ticks;
                  phase = PH_START_SCL;
               end
               PH_START_SCL: begin
                  scl = 1'b0;
                  wait_count = cfg.setup_ticks;
                  phase = PH_BYTE_BEGIN;
               end
               PH_BYTE_BEGIN: begin
                  drive = 1'b1;
                  bit_index = 3'd7;
                  wait_count = cfg.setup_ticks;
                  phase = PH_BIT_SET;
               end
               PH_BIT_SET: begin
                  sda = tx_byte[bit_index];
                  wait_count = cfg.bit_ticks;
                  phase = PH_BIT_HIGH;
               end
               PH_BIT_HIGH: begin
                  scl = 1'b1;
                  wait_count = cfg.bit_ticks;
                  phase = PH_BIT_LOW;
               end
               PH_BIT_LOW: begin
                  scl = 1'b0;
                  wait_count = cfg.bit_ticks;
                  if (bit_index == 3'd0) begin
                     phase = PH_ACK_RELEASE;
                  end else begin
                     bit_index = bit_index - 3'd1;
                     phase = PH_BIT_SET;
                  end
               end
               PH_ACK_RELEASE: begin
                  drive = 1'b0;
                  wait_count = cfg.setup_ticks;
                  phase = PH_ACK_HIGH;
               end
               PH_ACK_HIGH: begin
                  scl = 1'b1;
                  ack_count = '0;
                  wait_count = 8'd1;
                  phase = PH_ACK_POLL;
               end
               PH_ACK_POLL: begin
                  poll_ok   = 1'b0;
                  poll_fail = 1'b0;
                  // With no samples left the poll fails before looking at SDA.
                  if (ack_count >= cfg.ack_timeout) begin
                     poll_fail = 1'b1;
                  end else begin
                     ack_count = ack_count + 8'd1;
                     if (sda_in == 1'b0) begin
                        poll_ok = 1'b1;
                     end else if (ack_count >= cfg.ack_timeout) begin
                        poll_fail = 1'b1;
                     end else begin
                        wait_count = 8'd1;
                     end
                  end
                  if (poll_ok || poll_fail) begin
                     scl = 1'b0;
                     wait_count = cfg.setup_ticks;
                  end
                  if (poll_ok) begin
                     if (byte_index < 2'd2) begin
                        byte_index = byte_index + 2'd1;
                        phase = PH_BYTE_BEGIN;
                     end else begin
                        phase = PH_STOP_BEGIN;
                     end
                  end else if (poll_fail) begin
                     phase = PH_ABORT_END;
                  end
               end
               PH_STOP_BEGIN: begin
                  scl = 1'b0;
                  sda = 1'b0;
                  drive = 1'b1;
                  wait_count = cfg.setup_ticks;
                  phase = PH_STOP_SDA;
               end
               PH_STOP_SDA: begin
                  sda = 1'b1;
                  wait_count = cfg.setup_ticks;
                  phase = PH_STOP_SCL;
               end
               PH_STOP_SCL: begin
                  scl = 1'b1;
                  done = 1'b1;
                  phase = PH_IDLE;
               end
               PH_ABORT_END: begin
                  done = 1'b1;
                  err = 1'b1;
                  phase = PH_IDLE;
               end
               default: phase = PH_IDLE;
            endcase
         end

         levels.scl       = scl;
         levels.sda_out   = sda;
         levels.sda_drive = drive;
         levels.busy_res  = (phase != PH_IDLE);
         levels.done_res  = done;
         levels.ack_error = err;
         expected_levels.push_back(levels);
      endfunction

      function void compare_bit(input string name, input logic want, input logic got);
         if (got !== want) begin
            $error("%s: expected %0b, actual %0b", name, want, got);
            errors++;
         end
      endfunction

      function void check_levels(input result_type got);
         result_type want;
         if (expected_levels.size() == 0) begin
            $error("result transfer arrived with no expected line levels waiting");
            errors++;
            return;
         end
         want = expected_levels.pop_front();
         compare_bit("scl",       want.scl,       got.scl);
         compare_bit("sda_out",   want.sda_out,   got.sda_out);
         compare_bit("sda_drive", want.sda_drive, got.sda_drive);
         compare_bit("busy_res",  want.busy_res,  got.busy_res);
         compare_bit("done_res",  want.done_res,  got.done_res);
         compare_bit("ack_error", want.ack_error, got.ack_error);
      endfunction
   endclass

   // Every input of the block starts at a known value.
   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_stall;
   logic                       req_op           = OP_TICK;
   logic [6:0]                 req_reg_addr     = '0;
   logic [8:0]                 req_reg_data     = '0;
   logic                       req_sda_in       = 1'b1;
   logic                       rsp_valid;
   logic                       rsp_stall        = 1'b0;
   logic                       rsp_scl;
   logic                       rsp_sda_out;
   logic                       rsp_sda_drive;
   logic                       rsp_busy_res;
   logic                       rsp_done_res;
   logic                       rsp_ack_error;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data   = '0;

   i2c_line_scoreboard sb;
   int                 items_sent     = 0;
   int                 cycle_count    = 0;
   bit                 req_quiet      = 1'b0;
   int                 req_quiet_left = 0;

   i2c_codec_register_writer_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_reg_addr     (req_reg_addr),
      .req_reg_data     (req_reg_data),
      .req_sda_in       (req_sda_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl          (rsp_scl),
      .rsp_sda_out      (rsp_sda_out),
      .rsp_sda_drive    (rsp_sda_drive),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_ack_error    (rsp_ack_error),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #6 clock = ~clock;

   // The run ends with a failure if it has not finished by the cycle limit.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Idle lengths for both sides: mostly none, often a few cycles, rarely a long
   // stretch. A quiet stretch turns idling off entirely.
   function automatic int pick_gap(input bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 70) begin
         return 0;
      end else if (roll < 96) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Number of high SDA samples before the device acknowledges. A few polls get
   // no acknowledge at all and run into the timeout.
   function automatic int pick_highs();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
         return $urandom_range(0, 3);
      end else if (roll < 90) begin
         return $urandom_range(4, 12);
      end
      return NEVER_ACK;
   endfunction

   // Offer one request transfer, after an optional idle gap, and hold it until
   // the block takes it. Inputs are sampled right after the edge, so the
   // stall seen here is the one that decided the transfer.
   task automatic send_item(input logic op, input logic [6:0] reg_addr,
                            input logic [8:0] reg_data, input logic sda_in);
      int gap;
      if (req_quiet_left == 0) begin
         req_quiet      = ($urandom_range(0, 3) == 0);
         req_quiet_left = $urandom_range(40, 200);
      end else begin
         req_quiet_left--;
      end
      gap = pick_gap(req_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_reg_addr <= reg_addr;
      req_reg_data <= reg_data;
      req_sda_in   <= sda_in;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_request(op, reg_addr, reg_data, sda_in);
      items_sent++;
   endtask

   // Start one register write and keep ticking until it finishes. Each of the
   // three acknowledge polls pulls SDA low after the planned number of high
   // samples. Outside the polls SDA and the unused fields carry noise, and a
   // few ticks are requests that the busy block has to ignore.
   task automatic run_write(input logic [6:0] reg_addr, input logic [8:0] reg_data,
                            input int highs0, input int highs1, input int highs2,
                            input bit poke_busy);
      int   highs[3];
      int   polls;
      logic sda_in;
      highs[0] = highs0;
      highs[1] = highs1;
      highs[2] = highs2;
      polls = 0;
      send_item(OP_WRITE, reg_addr, reg_data, 1'($urandom_range(0, 1)));
      if (poke_busy) begin
         send_item(OP_WRITE, ~reg_addr, ~reg_data, 1'b1);
      end
      while (sb.phase != PH_IDLE) begin
         if (sb.phase == PH_ACK_POLL) begin
            sda_in = (polls < highs[sb.byte_index]) ? 1'b1 : 1'b0;
            polls++;
         end else begin
            polls = 0;
            sda_in = 1'($urandom_range(0, 1));
         end
         send_item(($urandom_range(0, 31) == 0) ? OP_WRITE : OP_TICK,
                   7'($urandom_range(0, 127)), 9'($urandom_range(0, 511)), sda_in);
      end
   endtask

   // Mostly complete writes with random content, with idle ticks in between.
   task automatic random_writes(input int count);
      int start;
      start = items_sent;
      while (items_sent - start < count) begin
         if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 4)) begin
               send_item(OP_TICK, 7'($urandom_range(0, 127)), 9'($urandom_range(0, 511)),
                         1'($urandom_range(0, 1)));
            end
         end else begin
            run_write(7'($urandom_range(0, 127)), 9'($urandom_range(0, 511)),
                      pick_highs(), pick_highs(), pick_highs(), 1'b0);
         end
      end
   endtask

   // Wait until every expected result transfer has come, plus a few cycles for
   // the pipeline to settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_levels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      sb.set_register(index, value);
   endtask

   // Registers change only while the block is idle and nothing is in flight.
   task automatic set_config(input logic [7:0] device_address, input logic [7:0] ack_timeout,
                             input logic [7:0] setup_ticks, input logic [7:0] bit_ticks);
      drain();
      write_csr(CSR_DEVICE_ADDRESS, device_address);
      write_csr(CSR_ACK_TIMEOUT, ack_timeout);
      write_csr(CSR_SETUP_TICKS, setup_ticks);
      write_csr(CSR_BIT_TICKS, bit_ticks);
      csr_write_enable <= 1'b0;
   endtask

   // Result side: check every result transfer, then choose the stall for the
   // next cycle. Quiet stretches leave the stall low for a while.
   initial begin : result_monitor
      result_type got;
      int         stall_left;
      int         quiet_left;
      bit         quiet;
      stall_left = 0;
      quiet_left = 0;
      quiet      = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            got.scl       = rsp_scl;
            got.sda_out   = rsp_sda_out;
            got.sda_drive = rsp_sda_drive;
            got.busy_res  = rsp_busy_res;
            got.done_res  = rsp_done_res;
            got.ack_error = rsp_ack_error;
            sb.check_levels(got);
         end
         if (quiet_left == 0) begin
            quiet      = ($urandom_range(0, 3) == 0);
            quiet_left = $urandom_range(50, 300);
         end else begin
            quiet_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
         end else begin
            stall_left = pick_gap(quiet);
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   initial begin : stimulus
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset settings. Idle ticks with both SDA levels
      // change nothing.
      send_item(OP_TICK, 7'h00, 9'h000, 1'b0);
      send_item(OP_TICK, 7'h7F, 9'h1FF, 1'b1);
      // All-ones fields with a request ignored while busy, then all-zero fields
      // with no acknowledge on the address byte.
      run_write(7'h7F, 9'h1FF, 0, 0, 0, 1'b1);
      run_write(7'h00, 9'h000, NEVER_ACK, 0, 0, 1'b0);
      // Missing acknowledge on the first and on the second register byte.
      run_write(7'h55, 9'h100, 2, NEVER_ACK, 0, 1'b0);
      run_write(7'h2A, 9'h0FF, 0, 1, NEVER_ACK, 1'b0);
      // Acknowledge on the very last sample the timeout allows.
      run_write(7'h01, 9'h1FE, 9, 9, 9, 1'b0);

      // Shortest timing, lowest device address, single-sample polls.
      set_config(8'h00, 8'd1, 8'd1, 8'd1);
      random_writes(40);

      // Highest device address and the longest poll.
      set_config(8'hFF, 8'd255, 8'd2, 8'd1);
      random_writes(40);

      // Zero wait lengths act as one tick, and a zero timeout fails every poll
      // without a sample.
      set_config(8'($urandom_range(0, 255)), 8'd0, 8'd0, 8'd0);
      random_writes(30);
      set_config(8'($urandom_range(0, 255)), 8'd3, 8'd0, 8'd0);
      random_writes(40);

      // Long setup waits and long bit phases: the address byte, then a timeout.
      set_config(8'($urandom_range(0, 255)), 8'd2, 8'd6, 8'd6);
      run_write(7'($urandom_range(0, 127)), 9'($urandom_range(0, 511)), NEVER_ACK, 0, 0,
                1'b0);

      // A few random settings with short timing.
      repeat (2) begin
         set_config(8'($urandom_range(0, 255)), 8'($urandom_range(1, 12)),
                    8'($urandom_range(0, 5)), 8'($urandom_range(0, 3)));
         random_writes(30);
      end

      // Everything has been offered; let the last results come out and make
      // sure no stray result transfer follows.
      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
